/* sv/circular_chaotic_map_sequence_macros.svh */
// Assertion helpers for the chaotic sequence generator.
`ifndef CIRCULAR_CHAOTIC_MAP_SEQUENCE_MACROS_SVH
`define CIRCULAR_CHAOTIC_MAP_SEQUENCE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CCMS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, during reset too.
`define CCMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ccms_pkg.sv */
package ccms_pkg;

  // Fixed-point layout
  localparam int unsigned FRAC_BITS = 15;
  localparam int unsigned A_BITS    = 15;
  localparam int unsigned CHIP_W    = FRAC_BITS + 1;
  localparam int unsigned SEED_W    = 16;
  localparam int unsigned N_W       = 2 * FRAC_BITS + 1;
  localparam int unsigned ACC_W     = N_W + 1;

  // Iteration counts of the shared subtract unit
  localparam int unsigned DIV_STEPS  = 2 * FRAC_BITS;
  localparam int unsigned SQRT_STEPS = FRAC_BITS + 1;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  localparam logic [A_BITS-1:0] A_RESET  = A_BITS'(1) << (A_BITS - 1);
  localparam logic [CHIP_W-1:0] CHIP_MAX = CHIP_W'((1 << FRAC_BITS) - 1);

  // Operation codes of an input item
  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_PREP,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } ccms_state_e;

  typedef struct packed {
    logic ld_item;
    logic do_sqr;
    logic do_prep;
    logic do_div;
    logic do_sqrt;
    logic ld_out;
  } ccms_ctrl_t;

endpackage

/* sv/circular_chaotic_map_sequence.sv */
// Circular-map chaotic spreading-sequence generator. A start item (op 0) turns
// the Q0.16 seed into a first chip by the map's inverse CDF; a next item (op 1)
// applies the circular map to the previous chip. Chips are signed Q1.15, roots
// floored, +1 saturated to 32767. One 32-bit subtract/compare unit is reused:
// a set-up step, 30 restoring-division steps, 16 square-root steps and a load
// of the output register, with a squaring step in front for next items. The
// result becomes valid in the same cycle as in_ready_o rises again; in_ready_o
// is low from the acceptance of an item until then, so the block works on one
// item at a time. A new item is accepted while a result waits in the output
// register, but its own result is held back until the waiting one is taken.
// Write deform_param only when idle;
// a written 0 is taken as 1.
`include "circular_chaotic_map_sequence_macros.svh"

module circular_chaotic_map_sequence
  import ccms_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [A_BITS-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     in_op_i,
  input  logic [SEED_W-1:0]        in_seed_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CHIP_W-1:0] out_chip_o
);

  ccms_state_e state_q, state_d;
  ccms_ctrl_t  ctrl;

  logic [A_BITS-1:0]        deform_q, deform_d;
  logic signed [CHIP_W-1:0] last_chip_q, last_chip_d;
  logic signed [CHIP_W-1:0] chip_q, chip_d;
  logic                     out_valid_q, out_valid_d;
  logic                     op_q, op_d;
  logic [SEED_W-1:0]        seed_q, seed_d;
  logic [N_W-1:0]           x2_q, x2_d;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [N_W-1:0]           quo_q, quo_d;
  logic [N_W-1:0]           den_q, den_d;
  logic [N_W-1:0]           root_q, root_d;
  logic [N_W-1:0]           bit_q, bit_d;
  logic                     neg_q, neg_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;

  logic [CHIP_W-1:0] mag;
  logic [A_BITS:0]   b_val;
  logic [SEED_W-1:0] two_a, two_b;
  logic [N_W-1:0]    big_a, big_b, one2;
  logic              in_band;
  logic [N_W-1:0]    num, den;
  logic              neg;
  logic [N_W-1:0]    num_c;
  logic [ACC_W-1:0]  alu_a, alu_b;
  logic [ACC_W:0]    alu_diff;
  logic              alu_ge;
  logic [CHIP_W-1:0] root16;
  logic              div_last, sqrt_last;

  assign div_last  = (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign sqrt_last = (cnt_q == CNT_W'(SQRT_STEPS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_op_i == OP_NEXT) ? ST_SQR : ST_PREP;
        end
      end
      ST_SQR:  state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV: begin
        if (div_last) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    ctrl        = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        ctrl.ld_item = in_valid_i;
      end
      ST_SQR:  ctrl.do_sqr  = 1'b1;
      ST_PREP: ctrl.do_prep = 1'b1;
      ST_DIV:  ctrl.do_div  = 1'b1;
      ST_SQRT: ctrl.do_sqrt = 1'b1;
      ST_DONE: ctrl.ld_out  = !out_valid_q || out_ready_i;
      default: ctrl = '0;
    endcase
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_chip_o  = chip_q;

  // Numerator, denominator and sign of the ratio to be rooted
  always_comb begin
    mag   = last_chip_q[CHIP_W-1] ? CHIP_W'(-last_chip_q) : CHIP_W'(last_chip_q);
    b_val = (A_BITS + 1)'(1 << A_BITS) - {1'b0, deform_q};
    two_a = {deform_q, 1'b0};
    two_b = {b_val[A_BITS-1:0], 1'b0};
    big_a = N_W'({deform_q, {(2 * FRAC_BITS - A_BITS){1'b0}}});
    big_b = N_W'({b_val[A_BITS-1:0], {(2 * FRAC_BITS - A_BITS){1'b0}}});
    one2  = N_W'(1) << (2 * FRAC_BITS);
    in_band = last_chip_q[CHIP_W-1] ? (x2_q <= big_a) : (x2_q < big_a);
    if (op_q == OP_START) begin
      if (seed_q < two_b) begin
        num = N_W'(two_b - seed_q);
        den = N_W'(two_b);
        neg = 1'b1;
      end else begin
        num = N_W'(seed_q - two_b);
        den = N_W'(two_a);
        neg = 1'b0;
      end
    end else if (in_band) begin
      num = big_a - x2_q;
      den = big_a;
      neg = 1'b0;
    end else begin
      num = (x2_q > one2) ? '0 : one2 - x2_q;
      den = big_b;
      neg = 1'b1;
    end
    num_c = (num > den) ? den : num;
  end

  // Shared subtract and compare unit
  always_comb begin
    if (ctrl.do_div) begin
      alu_a = {acc_q[ACC_W-2:0], 1'b0};
      alu_b = {1'b0, den_q};
    end else begin
      alu_a = acc_q;
      alu_b = {1'b0, N_W'(root_q + bit_q)};
    end
    alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    alu_ge   = !alu_diff[ACC_W];
  end

  // Datapath updates
  always_comb begin
    deform_d    = deform_q;
    last_chip_d = last_chip_q;
    chip_d      = chip_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    seed_d      = seed_q;
    x2_d        = x2_q;
    acc_d       = acc_q;
    quo_d       = quo_q;
    den_d       = den_q;
    root_d      = root_q;
    bit_d       = bit_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    root16      = root_q[CHIP_W-1:0];

    // Take a register write, zero reads as one
    if (cfg_valid_i) begin
      deform_d = (cfg_data_i == '0) ? A_BITS'(1) : cfg_data_i;
    end

    // Latch the item
    if (ctrl.ld_item) begin
      op_d   = in_op_i;
      seed_d = in_seed_i;
    end

    // Square the previous chip
    if (ctrl.do_sqr) begin
      x2_d = N_W'(32'(mag) * 32'(mag));
    end

    // Seed the division, an exact ratio of one gives the top quotient bit
    if (ctrl.do_prep) begin
      den_d = den;
      neg_d = neg;
      cnt_d = '0;
      if (num_c == den) begin
        quo_d = N_W'(1);
        acc_d = '0;
      end else begin
        quo_d = '0;
        acc_d = ACC_W'(num_c);
      end
    end

    // Advance one restoring division step
    if (ctrl.do_div) begin
      if (alu_ge) begin
        acc_d = alu_diff[ACC_W-1:0];
        quo_d = {quo_q[N_W-2:0], 1'b1};
      end else begin
        acc_d = alu_a;
        quo_d = {quo_q[N_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (div_last) begin
        cnt_d  = '0;
        acc_d  = ACC_W'(alu_ge ? {quo_q[N_W-2:0], 1'b1} : {quo_q[N_W-2:0], 1'b0});
        root_d = '0;
        bit_d  = N_W'(1) << (2 * FRAC_BITS);
      end
    end

    // Advance one square root step
    if (ctrl.do_sqrt) begin
      if (alu_ge) begin
        acc_d  = alu_diff[ACC_W-1:0];
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + CNT_W'(1);
    end

    // Drop a taken result
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Sign or saturate the root and hand it out
    if (ctrl.ld_out) begin
      if (neg_q) begin
        chip_d = CHIP_W'(-root16);
      end else begin
        chip_d = (root16 > CHIP_MAX) ? CHIP_MAX : root16;
      end
      last_chip_d = chip_d;
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      deform_q    <= A_RESET;
      last_chip_q <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      deform_q    <= deform_d;
      last_chip_q <= last_chip_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    chip_q <= chip_d;
    op_q   <= op_d;
    seed_q <= seed_d;
    x2_q   <= x2_d;
    acc_q  <= acc_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    neg_q  <= neg_d;
  end

  `CCMS_ASSERT(a_deform_nonzero, clk_i, rst_ni, deform_q != '0, "deform register holds zero")
  `CCMS_ASSERT(a_zero_write, clk_i, rst_ni, cfg_valid_i && cfg_data_i == '0 |=> deform_q == A_BITS'(1), "zero write not taken as one")
  `CCMS_ASSERT(a_rem_below_den, clk_i, rst_ni, state_q == ST_DIV |-> acc_q < ACC_W'(den_q), "division remainder not below divisor")
  `CCMS_ASSERT(a_root_range, clk_i, rst_ni, state_q == ST_DONE |-> root_q <= (N_W'(1) << FRAC_BITS), "square root above one")

endmodule

/* verif/ccms_chip_monitor.sv */
`timescale 1ns / 100ps

module ccms_chip_monitor
  import ccms_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [A_BITS-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     in_op_i,
  input  logic [SEED_W-1:0]        in_seed_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [CHIP_W-1:0] out_chip_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  localparam int unsigned SQ_BITS    = 2 * FRAC_BITS;
  localparam int unsigned A_SHIFT    = SQ_BITS - A_BITS;

  logic [A_BITS-1:0]        deform_a;
  logic signed [CHIP_W-1:0] prev_chip;
  logic signed [CHIP_W-1:0] chip_q[$];
  logic signed [CHIP_W-1:0] oldest_chip;
  int                       mismatches = 0;

  assign fail_count_o = mismatches;

  // floor(num * 2^SQ_BITS / den), numerator clipped to the denominator
  function automatic longint unsigned scaled_ratio(longint unsigned num,
                                                   longint unsigned den);
    longint unsigned clipped;
    clipped = (num > den) ? den : num;
    return (clipped << SQ_BITS) / den;
  endfunction

  // Integer square root, rounded down
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int k = 31; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Saturate a positive root at just below +1
  function automatic logic signed [CHIP_W-1:0] clip_pos(longint unsigned m);
    return (m > CHIP_MAX) ? CHIP_MAX : CHIP_W'(m);
  endfunction

  // Inverse CDF of the invariant density: seed to first chip
  function automatic logic signed [CHIP_W-1:0] seed_chip(logic [SEED_W-1:0] u,
                                                         logic [A_BITS-1:0] a);
    longint unsigned lo_span;
    lo_span = ((64'd1 << A_BITS) - a) << 1;
    if (u < lo_span)
      return CHIP_W'(-longint'(floor_sqrt(scaled_ratio(lo_span - u, lo_span))));
    return clip_pos(floor_sqrt(scaled_ratio(u - lo_span, 64'(a) << 1)));
  endfunction

  // One step of the circular map on the previous chip
  function automatic logic signed [CHIP_W-1:0] map_chip(logic signed [CHIP_W-1:0] x,
                                                        logic [A_BITS-1:0] a);
    longint          xs;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned a_full;
    longint unsigned b_full;
    longint unsigned one_full;
    logic            in_band;
    xs       = x;
    mag      = (xs < 0) ? -xs : xs;
    sq       = mag * mag;
    a_full   = 64'(a) << A_SHIFT;
    b_full   = ((64'd1 << A_BITS) - a) << A_SHIFT;
    one_full = 64'd1 << SQ_BITS;
    // the lower end of the inner band belongs to it, the upper end does not
    in_band  = (xs < 0) ? (sq <= a_full) : (sq < a_full);
    if (in_band) return clip_pos(floor_sqrt(scaled_ratio(a_full - sq, a_full)));
    if (sq > one_full) sq = one_full;
    return CHIP_W'(-longint'(floor_sqrt(scaled_ratio(one_full - sq, b_full))));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] chip mismatch: %s", $time, msg);
  endtask

  // Retire results, then track the register and predict each accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deform_a  = A_RESET;
      prev_chip = '0;
      chip_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (chip_q.size() == 0) begin
          report_mismatch($sformatf("chip %0d with no item outstanding", out_chip_i));
        end else begin
          oldest_chip = chip_q.pop_front();
          if (out_chip_i !== oldest_chip)
            report_mismatch($sformatf("got %0d, want %0d (a=%0d)",
                                      out_chip_i, oldest_chip, deform_a));
        end
      end
      if (cfg_valid_i && cfg_ready_i)
        deform_a = (cfg_data_i == '0) ? A_BITS'(1) : cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        prev_chip = (in_op_i == OP_START) ? seed_chip(in_seed_i, deform_a)
                                          : map_chip(prev_chip, deform_a);
        chip_q = {chip_q, prev_chip};
      end
      pending_o <= chip_q.size();
    end
  end

endmodule

/* verif/circular_chaotic_map_sequence_tb.sv */
`timescale 1ns / 100ps

module circular_chaotic_map_sequence_tb;
  import ccms_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 64;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 130;
  localparam int CALM_PHASE   = 4;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [A_BITS-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_op = OP_START;
  logic [SEED_W-1:0]        in_seed = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [CHIP_W-1:0] out_chip;

  logic calm = 1'b0;
  int   fail_count;
  int   pending;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   cur_a = A_RESET;
  int   a_low = A_RESET;
  int   a_high = A_RESET;
  int   n_settings = 1;
  int   n_starts = 0;
  int   n_steps = 0;

  always #5 clk = ~clk;

  circular_chaotic_map_sequence dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_op_i     (in_op),
    .in_seed_i   (in_seed),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_chip_o  (out_chip)
  );

  ccms_chip_monitor chip_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_op_i      (in_op),
    .in_seed_i    (in_seed),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_chip_i   (out_chip),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Stall the result side: mostly short drops, now and then a long hold
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(999) < 7) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(40);
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  // End the run when no channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer one item, with an occasional idle gap first
  task automatic send_item(input logic op, input logic [SEED_W-1:0] seed);
    if (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 100)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_seed  <= seed;
    do @(posedge clk); while (!in_ready);
    if (op == OP_START) n_starts++;
    else n_steps++;
  endtask

  // Drop valid and wait until every chip has come back
  task automatic drain();
    in_valid <= 1'b0;
    // let the count take in the item accepted at this edge
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_deform(input int value);
    cfg_valid <= 1'b1;
    cfg_data  <= A_BITS'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_a = (value == 0) ? 1 : value;
    if (cur_a < a_low) a_low = cur_a;
    if (cur_a > a_high) a_high = cur_a;
    n_settings++;
  endtask

  // Random seed, sometimes right at the sign change of the inverse CDF
  function automatic logic [SEED_W-1:0] pick_seed(input int a_eff);
    int knee;
    if ($urandom_range(7) == 0) begin
      knee = 2 * ((1 << A_BITS) - a_eff) + int'($urandom_range(8)) - 4;
      if (knee < 0) knee = 0;
      if (knee > (1 << SEED_W) - 1) knee = (1 << SEED_W) - 1;
      return SEED_W'(knee);
    end
    return SEED_W'($urandom);
  endfunction

  // Mostly a start followed by a run of steps; some lone items as noise
  task automatic run_random_phase(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(($urandom_range(1) == 0) ? OP_START : OP_NEXT, pick_seed(cur_a));
        sent++;
      end else begin
        send_item(OP_START, pick_seed(cur_a));
        sent++;
        repeat ($urandom_range(1, 24)) begin
          send_item(OP_NEXT, SEED_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int cfg_val;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a = 0.5 out of reset: step from the zero state, -1 and its image, seed extremes
    send_item(OP_NEXT, '0);
    send_item(OP_NEXT, '1);
    send_item(OP_START, '0);
    send_item(OP_NEXT, '0);
    send_item(OP_NEXT, '0);
    send_item(OP_START, '1);
    send_item(OP_START, SEED_W'(32768));
    send_item(OP_START, SEED_W'(32767));
    send_item(OP_NEXT, SEED_W'(16'h5555));
    send_item(OP_NEXT, SEED_W'(16'hAAAA));
    drain();

    // a written as zero is taken as the smallest step
    write_deform(0);
    send_item(OP_START, '0);
    send_item(OP_START, '1);
    send_item(OP_START, SEED_W'(1));
    send_item(OP_NEXT, '0);
    send_item(OP_NEXT, '0);
    drain();

    // largest a
    write_deform((1 << A_BITS) - 1);
    send_item(OP_START, '0);
    send_item(OP_START, '1);
    send_item(OP_START, SEED_W'(65534));
    send_item(OP_NEXT, '0);
    send_item(OP_NEXT, '0);
    drain();

    // a = 0.25: chips of exactly +sqrt(a) and -sqrt(a) hit both band edges
    write_deform(8192);
    send_item(OP_START, SEED_W'(53248));
    send_item(OP_NEXT, '0);
    send_item(OP_START, SEED_W'(36864));
    send_item(OP_NEXT, '0);
    drain();

    // random sequences over a sweep of settings, one phase without idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: cfg_val = A_RESET;
        1: cfg_val = 1;
        2: cfg_val = (1 << A_BITS) - 1;
        default: cfg_val = $urandom_range((1 << A_BITS) - 1);
      endcase
      write_deform(cfg_val);
      calm <= (p == CALM_PHASE);
      run_random_phase(PHASE_ITEMS);
      drain();
    end

    calm <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d starts and %0d map steps over %0d settings of a (%0d to %0d).",
             n_starts, n_steps, n_settings, a_low, a_high);
    $display("Chip mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
